/* rtl/hcl_pkg.sv */
// shared types, character codes and status codes of the content-length scanner
package hcl_pkg;

	localparam int unsigned OUT_W = 20;

	localparam logic [OUT_W-1:0] MAX_SIZE_RESET = 20'd65536;
	localparam logic [OUT_W-1:0] OUT_MAX = 20'hFFFFF;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;

	localparam logic [3:0] NAME_LEN = 4'd15;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_LEADWS,
		PH_SIGN,
		PH_DIGITS,
		PH_TRAIL,
		PH_DONE
	} phase_t;

	// "content-length:" one character per index
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h63;
			4'd1: c = 8'h6F;
			4'd2: c = 8'h6E;
			4'd3: c = 8'h74;
			4'd4: c = 8'h65;
			4'd5: c = 8'h6E;
			4'd6: c = 8'h74;
			4'd7: c = 8'h2D;
			4'd8: c = 8'h6C;
			4'd9: c = 8'h65;
			4'd10: c = 8'h6E;
			4'd11: c = 8'h67;
			4'd12: c = 8'h74;
			4'd13: c = 8'h68;
			4'd14: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* rtl/http_content_length_scanner.sv */
// content-length scanner: input register, per-byte scan and a registered result
// a byte is held in the input register; its result is registered for m_tvalid
// throughput: one byte per cycle; the scan state updates in the single stage after
// the input register; s_tready follows m_tready, so a held result stalls the input
// reset: arst_n clears all scan state and the valid flags, the size limit
// returns to 65536; first_byte on an item clears the scan state for a new request
module http_content_length_scanner #(
	parameter int unsigned COUNT_WIDTH = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [hcl_pkg::OUT_W-1:0]    cfg_wdata,     // max_request_size
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,       // data_byte
	input  logic [0:0]                   s_tuser,       // first_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [47:0]                  m_tdata        // status, total_size, header_size
);
	import hcl_pkg::*;

	localparam int unsigned SW = ((COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W) + 1;

	logic [OUT_W-1:0] max_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	logic                   out_valid_q;
	logic [47:0]            out_data_q;

	logic [COUNT_WIDTH-1:0] cnt_q, c_cnt, nx_cnt;
	logic [1:0]             emp_q, c_emp, nx_emp;
	logic                   ls_q, c_ls, nx_ls;
	logic [3:0]             nmp_q, c_nmp, nx_nmp;
	phase_t                 ph_q, c_ph, nx_ph;
	logic [OUT_W-1:0]       lv_q, c_lv, nx_lv;
	logic                   over_q, c_over, nx_over;
	logic                   neg_q, c_neg, nx_neg;
	logic                   inv_q, c_inv, nx_inv;
	logic                   dig_q, c_dig, nx_dig;
	logic                   found_q, c_found, nx_found;
	logic                   fin_q, c_fin, nx_fin;

	logic       advance, step;
	logic       hit;
	logic [7:0] lc;
	logic       is_blank, is_eol, is_digit;
	logic [23:0] acc;
	logic       do_digit, do_fail;

	logic [SW-1:0] bc_x, max_x, lv_x, sum_x;
	logic          sat, hdr_over, body_over;
	logic [1:0]    st;
	logic [OUT_W-1:0] msg, hdr;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign is_blank = (byte_s1 == CH_SP) || (byte_s1 == CH_TAB);
	assign is_eol   = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign is_digit = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign lc = ((byte_s1 >= CH_UP_A) && (byte_s1 <= CH_UP_Z)) ? byte_s1 + 8'd32 : byte_s1;
	// value times ten plus the digit, wide enough for the limit times ten
	assign acc = 24'({c_lv, 3'b000}) + 24'({c_lv, 1'b0}) + 24'(byte_s1 - CH_0);

	always_comb begin
		// first_byte clears the request state before this byte is scanned
		c_cnt   = first_s1 ? '0 : cnt_q;
		c_emp   = first_s1 ? 2'd0 : emp_q;
		c_ls    = first_s1 ? 1'b1 : ls_q;
		c_nmp   = first_s1 ? 4'd0 : nmp_q;
		c_ph    = first_s1 ? PH_SEARCH : ph_q;
		c_lv    = first_s1 ? '0 : lv_q;
		c_over  = first_s1 ? 1'b0 : over_q;
		c_neg   = first_s1 ? 1'b0 : neg_q;
		c_inv   = first_s1 ? 1'b0 : inv_q;
		c_dig   = first_s1 ? 1'b0 : dig_q;
		c_found = first_s1 ? 1'b0 : found_q;
		c_fin   = first_s1 ? 1'b0 : fin_q;

		nx_cnt = c_cnt; nx_emp = c_emp; nx_ls = c_ls; nx_nmp = c_nmp; nx_ph = c_ph;
		nx_lv = c_lv; nx_over = c_over; nx_neg = c_neg; nx_inv = c_inv;
		nx_dig = c_dig; nx_found = c_found; nx_fin = c_fin;
		hit = 1'b0;
		do_digit = 1'b0;
		do_fail = 1'b0;

		if (!c_fin) begin
			if (c_cnt != '1) begin
				nx_cnt = c_cnt + 1'b1;
			end

			case (c_ph)
				PH_SEARCH: begin
					if (c_ls || c_nmp != 4'd0) begin
						if (c_nmp < NAME_LEN && lc == name_char(c_nmp)) begin
							nx_nmp = c_nmp + 4'd1;
							if (c_nmp + 4'd1 == NAME_LEN) begin
								nx_found = 1'b1;
								nx_ph = PH_LEADWS;
							end
						end else begin
							nx_nmp = 4'd0;
						end
					end
				end
				PH_LEADWS: begin
					if (is_blank) begin
						nx_ph = PH_LEADWS;
					end else if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
						nx_neg = (byte_s1 == CH_MINUS);
						nx_ph = PH_SIGN;
					end else if (is_digit) begin
						do_digit = 1'b1;
						nx_ph = PH_DIGITS;
					end else begin
						do_fail = 1'b1;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						do_digit = 1'b1;
						nx_ph = PH_DIGITS;
					end else begin
						do_fail = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						do_digit = 1'b1;
					end else if (is_blank) begin
						nx_ph = PH_TRAIL;
					end else if (is_eol) begin
						nx_ph = PH_DONE;
					end else begin
						do_fail = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (is_eol) begin
						nx_ph = PH_DONE;
					end else if (!is_blank) begin
						do_fail = 1'b1;
					end
				end
				default: begin
					nx_ph = c_ph;
				end
			endcase

			if (do_fail) begin
				nx_inv = 1'b1;
				nx_ph = PH_DONE;
			end
			if (do_digit) begin
				nx_dig = 1'b1;
				if (!c_over) begin
					// saturate at the limit once the value passes it
					if (acc > 24'(max_q)) begin
						nx_over = 1'b1;
						nx_lv = max_q;
					end else begin
						nx_lv = acc[OUT_W-1:0];
					end
				end
			end

			nx_ls = (byte_s1 == CH_LF) && (c_emp == 2'd1);
			if (byte_s1 == CH_CR) begin
				nx_emp = (c_emp == 2'd2) ? 2'd3 : 2'd1;
			end else if (byte_s1 == CH_LF) begin
				hit = (c_emp == 2'd3);
				nx_emp = (c_emp == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				nx_emp = 2'd0;
			end
			if (hit) begin
				nx_fin = 1'b1;
			end
		end
	end

	assign bc_x  = SW'(nx_cnt);
	assign max_x = SW'(max_q);
	assign lv_x  = SW'(nx_lv);
	assign sum_x = bc_x + (nx_found ? lv_x : '0);
	assign sat   = (nx_cnt == '1);
	assign hdr_over = sat || (bc_x > max_x);
	// the header fits here, so sum against the limit matches limit minus count
	assign body_over = nx_found && (nx_over || (nx_neg && nx_lv != '0) || (lv_x + bc_x > max_x));

	always_comb begin
		st = ST_OK;
		msg = '0;
		if (nx_found && (nx_inv || !nx_dig)) begin
			st = ST_INVALID;
		end else if (hdr_over || body_over) begin
			st = ST_OVER;
		end else begin
			msg = sum_x[OUT_W-1:0];
		end
		hdr = (bc_x > SW'(OUT_MAX)) ? OUT_MAX : bc_x[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_SIZE_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			first_s1 <= s_tuser[0];
		end
		if (step && hit) begin
			out_data_q <= {6'd0, hdr, msg, st};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			emp_q <= 2'd0;
			ls_q <= 1'b1;
			nmp_q <= 4'd0;
			ph_q <= PH_SEARCH;
			lv_q <= '0;
			over_q <= 1'b0;
			neg_q <= 1'b0;
			inv_q <= 1'b0;
			dig_q <= 1'b0;
			found_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (step) begin
			cnt_q <= nx_cnt;
			emp_q <= nx_emp;
			ls_q <= nx_ls;
			nmp_q <= nx_nmp;
			ph_q <= nx_ph;
			lv_q <= nx_lv;
			over_q <= nx_over;
			neg_q <= nx_neg;
			inv_q <= nx_inv;
			dig_q <= nx_dig;
			found_q <= nx_found;
			fin_q <= nx_fin;
		end
	end

	// input side only stalls when a byte is held and the result register is blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_INVALID ||
			m_tdata[1:0] == ST_OVER))
		else $error("undefined status code");

	a_msg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[21:2] == '0))
		else $error("message size set on a failed request");

	// a header end needs at least the four bytes of the blank line
	a_hdr_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[41:22] >= 20'd4))
		else $error("header size below four bytes");

endmodule
